// ===== rtl/tht_pkg.sv =====
`default_nettype none
package tht_pkg;

    localparam int unsigned AdcW  = 12;
    localparam int unsigned TempW = 9;
    localparam int unsigned HystW = 7;
    localparam int unsigned ModeW = 2;
    localparam int unsigned IdxW  = 4;
    localparam int unsigned PcW   = 4;
    localparam int unsigned DiffW = 8;
    localparam int unsigned DeltW = 6;
    localparam int unsigned NumW  = DiffW + DeltW;

    localparam logic [IdxW-1:0] LastIdx = 4'd12;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_HYST   = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [ModeW-1:0] MODE_AUTO = 2'd0;
    localparam logic [ModeW-1:0] MODE_ON   = 2'd1;
    localparam logic [ModeW-1:0] MODE_OFF  = 2'd2;

    localparam logic [TempW-1:0] TargetMax  = 9'd500;
    localparam logic [HystW-1:0] HystMax    = 7'd100;
    localparam logic [TempW-1:0] TargetRst  = 9'd250;
    localparam logic [HystW-1:0] HystRst    = 7'd20;
    localparam logic [TempW-1:0] AvgRst     = 9'd250;

    localparam logic [2:0] OP_WAIT   = 3'd0;
    localparam logic [2:0] OP_CLHI   = 3'd1;
    localparam logic [2:0] OP_CLLO   = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_MUL    = 3'd4;
    localparam logic [2:0] OP_DIV    = 3'd5;
    localparam logic [2:0] OP_INTERP = 3'd6;
    localparam logic [2:0] OP_AVG    = 3'd7;

    localparam logic [2:0] C_NEVER    = 3'd0;
    localparam logic [2:0] C_NO_REQ   = 3'd1;
    localparam logic [2:0] C_GE_TOP   = 3'd2;
    localparam logic [2:0] C_LE_BOT   = 3'd3;
    localparam logic [2:0] C_NOT_SEG  = 3'd4;
    localparam logic [2:0] C_DIV_MORE = 3'd5;
    localparam logic [2:0] C_OUT_BUSY = 3'd6;

    localparam logic [PcW-1:0] S_IDLE   = 4'd0;
    localparam logic [PcW-1:0] S_CLHI   = 4'd1;
    localparam logic [PcW-1:0] S_CLLO   = 4'd2;
    localparam logic [PcW-1:0] S_SEARCH = 4'd3;
    localparam logic [PcW-1:0] S_MUL    = 4'd4;
    localparam logic [PcW-1:0] S_DIV    = 4'd5;
    localparam logic [PcW-1:0] S_INTERP = 4'd6;
    localparam logic [PcW-1:0] S_AVG    = 4'd7;
    localparam logic [PcW-1:0] S_CTRL   = 4'd8;
    localparam logic [PcW-1:0] S_EMIT   = 4'd9;

    localparam logic [2:0] OP_CTRL = 3'd0;

    typedef struct packed {
        logic [2:0]     op;
        logic           ctrl;
        logic           emit;
        logic [2:0]     cond;
        logic           last;
        logic [PcW-1:0] target;
    } t_uword;

    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        w = '{op: OP_WAIT, ctrl: 1'b0, emit: 1'b0, cond: C_NEVER, last: 1'b1,
              target: S_IDLE};
        case (pc)
            S_IDLE:   w = '{OP_WAIT,   1'b0, 1'b0, C_NO_REQ,   1'b0, S_IDLE};
            S_CLHI:   w = '{OP_CLHI,   1'b0, 1'b0, C_GE_TOP,   1'b0, S_AVG};
            S_CLLO:   w = '{OP_CLLO,   1'b0, 1'b0, C_LE_BOT,   1'b0, S_AVG};
            S_SEARCH: w = '{OP_SEARCH, 1'b0, 1'b0, C_NOT_SEG,  1'b0, S_SEARCH};
            S_MUL:    w = '{OP_MUL,    1'b0, 1'b0, C_NEVER,    1'b0, S_IDLE};
            S_DIV:    w = '{OP_DIV,    1'b0, 1'b0, C_DIV_MORE, 1'b0, S_DIV};
            S_INTERP: w = '{OP_INTERP, 1'b0, 1'b0, C_NEVER,    1'b0, S_IDLE};
            S_AVG:    w = '{OP_AVG,    1'b0, 1'b0, C_NEVER,    1'b0, S_IDLE};
            S_CTRL:   w = '{OP_CTRL,   1'b1, 1'b0, C_NEVER,    1'b0, S_IDLE};
            S_EMIT:   w = '{OP_WAIT,   1'b0, 1'b1, C_OUT_BUSY, 1'b1, S_EMIT};
            default:  w = '{OP_WAIT,   1'b0, 1'b0, C_NEVER,    1'b1, S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [AdcW-1:0] ntc_code(input logic [IdxW-1:0] i);
        logic [AdcW-1:0] c;
        case (i)
            4'd0:    c = 12'd3134;
            4'd1:    c = 12'd2963;
            4'd2:    c = 12'd2727;
            4'd3:    c = 12'd2499;
            4'd4:    c = 12'd2278;
            4'd5:    c = 12'd2160;
            4'd6:    c = 12'd2047;
            4'd7:    c = 12'd1938;
            4'd8:    c = 12'd1827;
            4'd9:    c = 12'd1624;
            4'd10:   c = 12'd1424;
            4'd11:   c = 12'd1232;
            4'd12:   c = 12'd1085;
            default: c = 12'd1085;
        endcase
        return c;
    endfunction

    function automatic logic [TempW-1:0] ntc_temp(input logic [IdxW-1:0] i);
        logic [TempW-1:0] t;
        case (i)
            4'd0:    t = 9'd0;
            4'd1:    t = 9'd50;
            4'd2:    t = 9'd100;
            4'd3:    t = 9'd150;
            4'd4:    t = 9'd200;
            4'd5:    t = 9'd225;
            4'd6:    t = 9'd250;
            4'd7:    t = 9'd275;
            4'd8:    t = 9'd300;
            4'd9:    t = 9'd350;
            4'd10:   t = 9'd400;
            4'd11:   t = 9'd450;
            4'd12:   t = 9'd500;
            default: t = 9'd500;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tht_in_if.sv =====
`default_nettype none
interface tht_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/tht_out_if.sv =====
`default_nettype none
interface tht_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] instant_temp;
    logic [8:0] smoothed_temp;
    logic       drive_on;

    modport source (output valid, output instant_temp, output smoothed_temp,
                    output drive_on, input ready);
    modport sink   (input valid, input instant_temp, input smoothed_temp,
                    input drive_on, output ready);
endinterface
`default_nettype wire

// ===== rtl/thermistor_hysteresis_thermostat_top.sv =====
// Thermistor thermostat with hysteresis.
// i_in carries one 12-bit ADC request of the thermistor divider; o_out returns
// one result per request: the interpolated temperature, the smoothed
// temperature and the drive gate, the temperatures in tenths of a degree.
// Configuration goes through i_cfg_wr_en / i_cfg_index / i_cfg_data while the
// block is idle (user's duty, unchecked by the block): 0 setpoint, 1 hysteresis
// band, 2 drive mode. Out-of-range setpoint or band writes are dropped.
// A small microcode sequencer steps a shared datapath: clamp checks, a linear
// segment search (one table point per cycle), one multiply and a restoring
// divide. A sample clamped high goes from the first clamp check to the average,
// drive and emit steps; one clamped low passes both checks first; any other
// also runs search, multiply, divide and interpolate in between. One request
// is in flight at a time; i_in.ready is high only while the sequencer idles,
// so a request is taken at the earliest in the cycle after the previous
// result is loaded, and the result register lets the next request enter while
// that result still waits. If the receiver stalls, the result holds in the
// output register and the sequencer waits at its last step until it frees.
// Reset clears the handshake, sets setpoint 250, band 20, automatic mode,
// smoothed temperature 250 and drive off.
`default_nettype none
module thermistor_hysteresis_thermostat_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    tht_in_if.sink                      i_in,
    tht_out_if.source                   o_out,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [tht_pkg::TempW-1:0] i_cfg_data
);
    import tht_pkg::*;

    logic [PcW-1:0]   r_pc, n_pc;
    logic [AdcW-1:0]  r_adc;
    logic [IdxW-1:0]  r_idx;
    logic [NumW-1:0]  r_num;
    logic [DiffW-1:0] r_rem;
    logic [3:0]       r_cnt;
    logic [TempW-1:0] r_inst;
    logic [TempW-1:0] r_avg;
    logic             r_drive;
    logic [TempW-1:0] r_target;
    logic [HystW-1:0] r_hyst;
    logic [ModeW-1:0] r_mode;
    logic             r_out_valid;
    logic [TempW-1:0] r_out_inst;
    logic [TempW-1:0] r_out_avg;
    logic             r_out_drive;

    t_uword           w_uw;
    logic             w_cond;
    logic             w_accept;
    logic             w_out_busy;
    logic [IdxW-1:0]  w_idx_nx;
    logic [AdcW-1:0]  w_code_lo;
    logic [AdcW-1:0]  w_code_hi;
    logic [DiffW-1:0] w_diff;
    logic [DiffW-1:0] w_span;
    logic [DeltW-1:0] w_delta;
    logic [DiffW:0]   w_rem_sh;
    logic             w_ge;
    logic [TempW:0]   w_sum;
    logic [TempW:0]   w_upper;
    logic [TempW:0]   w_lower_chk;
    logic [HystW-2:0] w_half;

    assign w_uw       = ucode(r_pc);
    assign i_in.ready = (r_pc == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_busy = r_out_valid && !o_out.ready;

    assign w_idx_nx  = r_idx + 4'd1;
    assign w_code_hi = ntc_code(r_idx);
    assign w_code_lo = ntc_code(w_idx_nx);
    assign w_diff    = DiffW'(r_adc - w_code_lo);
    assign w_span    = DiffW'(w_code_hi - w_code_lo);
    assign w_delta   = DeltW'(ntc_temp(w_idx_nx) - ntc_temp(r_idx));
    assign w_rem_sh  = {r_rem, r_num[NumW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_span});

    assign w_sum       = {1'b0, r_avg} + {1'b0, r_inst};
    assign w_half      = r_hyst[HystW-1:1];
    assign w_upper     = {1'b0, r_target} + (TempW+1)'(w_half);
    assign w_lower_chk = {1'b0, r_avg} + (TempW+1)'(w_half);

    always_comb begin
        case (w_uw.cond)
            C_NO_REQ:   w_cond = !i_in.valid;
            C_GE_TOP:   w_cond = (r_adc >= ntc_code(4'd0));
            C_LE_BOT:   w_cond = (r_adc <= ntc_code(LastIdx));
            C_NOT_SEG:  w_cond = (r_adc < w_code_lo);
            C_DIV_MORE: w_cond = (r_cnt != 4'(NumW - 1));
            C_OUT_BUSY: w_cond = w_out_busy;
            default:    w_cond = 1'b0;
        endcase
        if (w_cond) begin
            n_pc = w_uw.target;
        end else if (w_uw.last) begin
            n_pc = S_IDLE;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_avg       <= AvgRst;
            r_drive     <= 1'b0;
            r_target    <= TargetRst;
            r_hyst      <= HystRst;
            r_mode      <= MODE_AUTO;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_TARGET: if (i_cfg_data <= TargetMax) r_target <= i_cfg_data;
                    REG_HYST: begin
                        if (i_cfg_data[HystW-1:0] != '0 && i_cfg_data[HystW-1:0] <= HystMax) begin
                            r_hyst <= i_cfg_data[HystW-1:0];
                        end
                    end
                    REG_MODE:   r_mode <= i_cfg_data[ModeW-1:0];
                    default:    ;
                endcase
            end

            if (w_uw.ctrl) begin
                if (r_mode == MODE_ON) begin
                    r_drive <= 1'b1;
                end else if (r_mode == MODE_OFF) begin
                    r_drive <= 1'b0;
                end else if ({1'b0, r_avg} > w_upper) begin
                    r_drive <= 1'b1;
                end else if (w_lower_chk < {1'b0, r_target}) begin
                    r_drive <= 1'b0;
                end
            end

            if (w_uw.emit && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_uw.op)
                OP_AVG:  r_avg <= w_sum[TempW:1];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.emit && !w_out_busy) begin
            r_out_inst  <= r_inst;
            r_out_avg   <= r_avg;
            r_out_drive <= r_drive;
        end
        case (w_uw.op)
            OP_WAIT: begin
                if (w_accept) begin
                    r_adc <= i_in.adc_sample;
                    r_idx <= '0;
                end
            end
            OP_CLHI:   r_inst <= ntc_temp(4'd0);
            OP_CLLO:   r_inst <= ntc_temp(LastIdx);
            OP_SEARCH: if (r_adc < w_code_lo) r_idx <= w_idx_nx;
            OP_MUL: begin
                r_num <= NumW'(w_diff) * NumW'(w_delta);
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_rem <= w_ge ? DiffW'(w_rem_sh - {1'b0, w_span}) : DiffW'(w_rem_sh);
                r_num <= {r_num[NumW-2:0], w_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            OP_INTERP: r_inst <= ntc_temp(w_idx_nx) - r_num[TempW-1:0];
            default: ;
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.instant_temp  = r_out_inst;
    assign o_out.smoothed_temp = r_out_avg;
    assign o_out.drive_on      = r_out_drive;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import tht_pkg::*;

    localparam int NumPts     = 13;
    localparam int NumProbes  = 22;
    localparam int NumPhases  = 16;
    localparam int PhaseItems = 100;
    localparam int CalmPhase  = 9;

    localparam logic [1:0]       REG_SPARE  = 2'd3;
    localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

    localparam int CAL_CODE [NumPts] = '{3134, 2963, 2727, 2499, 2278, 2160, 2047,
                                         1938, 1827, 1624, 1424, 1232, 1085};
    localparam int CAL_TENTHS [NumPts] = '{0, 50, 100, 150, 200, 225, 250,
                                           275, 300, 350, 400, 450, 500};

    typedef struct packed {
        logic [TempW-1:0] instant;
        logic [TempW-1:0] smoothed;
        logic             drive;
    } t_reading;

    typedef struct packed {
        logic [AdcW-1:0]  adc;
        logic             known;
        logic [TempW-1:0] tenths;
    } t_probe;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [TempW-1:0] cfg_data;

    tht_in_if  in_if ();
    tht_out_if out_if ();

    thermistor_hysteresis_thermostat_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    logic [TempW-1:0] set_target;
    logic [HystW-1:0] set_band;
    logic [ModeW-1:0] set_mode;
    logic [TempW-1:0] avg_tenths;
    logic             gate_on;

    t_reading pending_readings [$];
    int       n_err;
    int       n_sent;
    int       n_checked;
    int       n_toggles;
    int       n_settings;
    bit       calm;

    t_probe probes [NumProbes] = '{
        '{12'd4095, 1'b1, 9'd0},
        '{12'd3134, 1'b1, 9'd0},
        '{12'd3135, 1'b1, 9'd0},
        '{12'd3133, 1'b0, 9'd0},
        '{12'd2963, 1'b1, 9'd50},
        '{12'd2727, 1'b1, 9'd100},
        '{12'd2499, 1'b1, 9'd150},
        '{12'd2278, 1'b1, 9'd200},
        '{12'd2160, 1'b1, 9'd225},
        '{12'd2047, 1'b1, 9'd250},
        '{12'd1938, 1'b1, 9'd275},
        '{12'd1827, 1'b1, 9'd300},
        '{12'd1624, 1'b1, 9'd350},
        '{12'd1424, 1'b1, 9'd400},
        '{12'd1232, 1'b1, 9'd450},
        '{12'd1085, 1'b1, 9'd500},
        '{12'd1086, 1'b0, 9'd0},
        '{12'd1084, 1'b1, 9'd500},
        '{12'd0,    1'b1, 9'd500},
        '{12'd2730, 1'b0, 9'd0},
        '{12'd1365, 1'b0, 9'd0},
        '{12'd2100, 1'b0, 9'd0}
    };

    function automatic logic [TempW-1:0] adc_to_tenths(input logic [AdcW-1:0] adc);
        int code;
        int k;
        code = int'(adc);
        if (code >= CAL_CODE[0]) return TempW'(CAL_TENTHS[0]);
        if (code <= CAL_CODE[NumPts-1]) return TempW'(CAL_TENTHS[NumPts-1]);
        for (k = 0; k < NumPts - 1; k++) begin
            if (code <= CAL_CODE[k] && code >= CAL_CODE[k+1]) begin
                return TempW'(CAL_TENTHS[k+1] -
                              ((code - CAL_CODE[k+1]) * (CAL_TENTHS[k+1] - CAL_TENTHS[k])) /
                              (CAL_CODE[k] - CAL_CODE[k+1]));
            end
        end
        return TempW'(250);
    endfunction

    function automatic t_reading advance_thermostat(input logic [AdcW-1:0] adc);
        t_reading r;
        int       half;
        int       upper;
        int       lower;
        logic     prev;
        r.instant  = adc_to_tenths(adc);
        avg_tenths = TempW'((int'(avg_tenths) + int'(r.instant)) / 2);
        prev  = gate_on;
        half  = int'(set_band) / 2;
        upper = int'(set_target) + half;
        lower = int'(set_target) - half;
        if (set_mode == MODE_ON) begin
            gate_on = 1'b1;
        end else if (set_mode == MODE_OFF) begin
            gate_on = 1'b0;
        end else if (int'(avg_tenths) > upper) begin
            gate_on = 1'b1;
        end else if (int'(avg_tenths) < lower) begin
            gate_on = 1'b0;
        end
        if (gate_on != prev) n_toggles++;
        r.smoothed = avg_tenths;
        r.drive    = gate_on;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [TempW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_TARGET: if (data <= TargetMax) set_target = data;
            REG_HYST: begin
                if (data[HystW-1:0] != '0 && data[HystW-1:0] <= HystMax) begin
                    set_band = data[HystW-1:0];
                end
            end
            REG_MODE: set_mode = data[ModeW-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [AdcW-1:0] adc, input logic known,
                               input logic [TempW-1:0] tenths);
        t_reading r;
        while (!calm && $urandom_range(0, 99) < 37) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.adc_sample <= adc;
        do @(posedge i_clk); while (!in_if.ready);
        r = advance_thermostat(adc);
        if (known) r.instant = tenths;
        pending_readings.push_back(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_setting(input int ph);
        int         nw;
        int         w;
        logic [1:0] idx;
        logic [TempW-1:0] data;
        case (ph)
            0: begin
                write_reg(REG_TARGET, TempW'(0));
                write_reg(REG_HYST, TempW'(1));
                write_reg(REG_MODE, TempW'(MODE_AUTO));
            end
            1: begin
                write_reg(REG_TARGET, TargetMax);
                write_reg(REG_HYST, TempW'(HystMax));
            end
            2: write_reg(REG_MODE, TempW'(MODE_ON));
            3: begin
                write_reg(REG_MODE, TempW'(MODE_AUTO));
                write_reg(REG_TARGET, TargetRst);
                write_reg(REG_HYST, TempW'(HystRst));
            end
            4: write_reg(REG_MODE, TempW'(MODE_OFF));
            5: write_reg(REG_MODE, TempW'(MODE_SPARE));
            6: begin
                write_reg(REG_TARGET, 9'd511);
                write_reg(REG_TARGET, 9'd501);
                write_reg(REG_HYST, 9'd0);
                write_reg(REG_HYST, 9'd101);
                write_reg(REG_HYST, 9'h1FF);
                write_reg(REG_SPARE, 9'h1FF);
                write_reg(REG_MODE, TempW'(MODE_AUTO));
            end
            7: begin
                write_reg(REG_HYST, 9'h185);
                write_reg(REG_TARGET, 9'd300);
            end
            default: begin
                nw = $urandom_range(1, 3);
                for (w = 0; w < nw; w++) begin
                    idx  = 2'($urandom_range(0, 3));
                    data = TempW'($urandom_range(0, 511));
                    if ($urandom_range(0, 3) != 0) begin
                        case (idx)
                            REG_TARGET: data = TempW'($urandom_range(0, 500));
                            REG_HYST:   data = TempW'($urandom_range(1, 100));
                            REG_MODE:   data = TempW'($urandom_range(0, 3));
                            default: ;
                        endcase
                    end
                    write_reg(idx, data);
                end
            end
        endcase
        n_settings++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_readings.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result instant %0d smoothed %0d drive %0b", $time,
                         out_if.instant_temp, out_if.smoothed_temp, out_if.drive_on);
            end else begin
                want = pending_readings.pop_front();
                n_checked++;
                if (out_if.instant_temp !== want.instant) begin
                    n_err++;
                    $display("%0t: instant_temp expected %0d actual %0d", $time,
                             want.instant, out_if.instant_temp);
                end
                if (out_if.smoothed_temp !== want.smoothed) begin
                    n_err++;
                    $display("%0t: smoothed_temp expected %0d actual %0d", $time,
                             want.smoothed, out_if.smoothed_temp);
                end
                if (out_if.drive_on !== want.drive) begin
                    n_err++;
                    $display("%0t: drive_on expected %0b actual %0b", $time,
                             want.drive, out_if.drive_on);
                end
            end
        end
    end

    initial begin
        int              ph;
        int              n;
        int              k;
        int              walk;
        int              pick;
        logic [AdcW-1:0] adc;
        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_TARGET;
        cfg_data         = '0;
        in_if.valid      = 1'b0;
        in_if.adc_sample = '0;
        calm       = 1'b0;
        n_err      = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_toggles  = 0;
        n_settings = 0;
        set_target = TargetRst;
        set_band   = HystRst;
        set_mode   = MODE_AUTO;
        avg_tenths = AvgRst;
        gate_on    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < NumProbes; k++) begin
            send_sample(probes[k].adc, probes[k].known, probes[k].tenths);
        end
        in_if.valid <= 1'b0;
        drain();

        walk = 2047;
        for (ph = 0; ph < NumPhases; ph++) begin
            apply_setting(ph);
            calm = (ph == CalmPhase);
            for (n = 0; n < PhaseItems; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    adc = AdcW'($urandom_range(0, 4095));
                end else if (pick < 6) begin
                    adc = AdcW'($urandom_range(1085, 3134));
                end else begin
                    // drift slowly so the average lingers inside the band
                    walk += int'($urandom_range(0, 80)) - 40;
                    if (walk < 1000) walk = 1000;
                    if (walk > 3200) walk = 3200;
                    adc = AdcW'(walk);
                end
                send_sample(adc, 1'b0, '0);
            end
            in_if.valid <= 1'b0;
            calm = 1'b0;
            drain();
        end
        repeat (40) @(posedge i_clk);

        $display("sent %0d samples under %0d register settings, compared %0d results,",
                 n_sent, n_settings + 1, n_checked);
        $display("drive changed state %0d times, %0d mismatches", n_toggles, n_err);
        if (n_err == 0) begin
            $display("[thermistor_hysteresis_thermostat_top] OK");
        end else begin
            $display("[thermistor_hysteresis_thermostat_top] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_readings.size());
        $display("[thermistor_hysteresis_thermostat_top] ERROR");
        $finish;
    end

endmodule
